[design/gepc_pkg.sv]
// gepc_pkg: shared types and constants for the grid escape path counter
// used by gepc_dp, gepc_ctrl and grid_escape_path_counter
package gepc_pkg;

    localparam int BUDGET_W = 7;
    localparam int START_W  = 6;
    localparam int CFG_W    = 7;
    localparam int COUNT_W  = 30;
    localparam int SIZE_W   = 9;

    localparam logic [COUNT_W-1:0] PATH_MOD = 30'd1000000007;

    localparam logic [2:0] PHASE_UP    = 3'd0;
    localparam logic [2:0] PHASE_DOWN  = 3'd1;
    localparam logic [2:0] PHASE_LEFT  = 3'd2;
    localparam logic [2:0] PHASE_RIGHT = 3'd3;
    localparam logic [2:0] PHASE_LAST  = 3'd4;

    localparam logic REG_ROWS = 1'b0;
    localparam logic REG_COLS = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_SWEEP,
        ST_FETCH,
        ST_CAPTURE,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        NB_ZERO,
        NB_ONE,
        NB_RAM
    } nb_kind_t;

    typedef struct packed {
        logic load;
        logic zero_res;
        logic sweep;
        logic fetch;
        logic capture;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic bad_start;
        logic budget_zero;
        logic sweep_done;
        logic out_free;
    } status_t;

endpackage

[design/gepc_ram.sv]
// gepc_ram: generic single write port memory with registered read
// no dependencies
module gepc_ram #(
    parameter int WIDTH = 30,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[design/gepc_dp.sv]
// gepc_dp: datapath with config registers, sweep counters, layer stores and output register
// depends on gepc_pkg and gepc_ram
module gepc_dp #(
    parameter int ROWS_MAX  = 64,
    parameter int COLS_MAX  = 64,
    parameter int MOVES_MAX = 64
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_wr_en,
    input  logic                         cfg_index,
    input  logic [gepc_pkg::CFG_W-1:0]   cfg_wdata,
    input  logic [23:0]                  s_tdata,
    input  gepc_pkg::cmd_t               cmd,
    output gepc_pkg::status_t            status,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [31:0]                  m_tdata,
    output logic                         m_tuser
);

    localparam int RW    = (ROWS_MAX > 1) ? $clog2(ROWS_MAX) : 1;
    localparam int CW    = (COLS_MAX > 1) ? $clog2(COLS_MAX) : 1;
    localparam int AW    = RW + CW;
    localparam int DEPTH = 1 << AW;
    localparam logic [10:0] MOVES_CAP = 11'(MOVES_MAX);
    localparam logic [gepc_pkg::SIZE_W-1:0] ROWS_CAP = gepc_pkg::SIZE_W'(ROWS_MAX);
    localparam logic [gepc_pkg::SIZE_W-1:0] COLS_CAP = gepc_pkg::SIZE_W'(COLS_MAX);

    logic [gepc_pkg::CFG_W-1:0]    grid_rows_reg, grid_cols_reg;
    logic [gepc_pkg::SIZE_W-1:0]   rows_reg, cols_reg;
    logic [gepc_pkg::BUDGET_W-1:0] budget_reg, layer_reg;
    logic [gepc_pkg::START_W-1:0]  sr_reg, sc_reg;
    logic                          bad_reg;
    logic [RW-1:0]                 row_reg;
    logic [CW-1:0]                 col_reg;
    logic [2:0]                    phase_reg;
    logic [gepc_pkg::COUNT_W-1:0]  acc_reg;
    gepc_pkg::nb_kind_t            kind_reg, kind_next;
    logic [gepc_pkg::COUNT_W-1:0]  res_count_reg;
    logic                          res_bad_reg;
    logic                          m_valid_reg, m_bad_reg;
    logic [gepc_pkg::COUNT_W-1:0]  m_count_reg;

    logic [gepc_pkg::BUDGET_W-1:0] in_budget, budget_sat;
    logic [gepc_pkg::START_W-1:0]  in_row, in_col;
    logic [gepc_pkg::SIZE_W-1:0]   rows_sat, cols_sat;
    logic                          row_last, col_last, layer_last;
    logic                          nb_out;
    logic [RW-1:0]                 nb_row;
    logic [CW-1:0]                 nb_col;
    logic [AW-1:0]                 raddr, waddr;
    logic [gepc_pkg::COUNT_W-1:0]  rdata0, rdata1, rdata_sel, contrib, red;
    logic [gepc_pkg::COUNT_W:0]    sum;
    logic                          wr_cell, we0, we1, rsel;

    assign in_budget = s_tdata[6:0];
    assign in_row    = s_tdata[12:7];
    assign in_col    = s_tdata[18:13];

    assign budget_sat = ({4'b0, in_budget} > MOVES_CAP) ? MOVES_CAP[6:0] : in_budget;
    assign rows_sat = (gepc_pkg::SIZE_W'(grid_rows_reg) > ROWS_CAP) ? ROWS_CAP
                                                                    : gepc_pkg::SIZE_W'(grid_rows_reg);
    assign cols_sat = (gepc_pkg::SIZE_W'(grid_cols_reg) > COLS_CAP) ? COLS_CAP
                                                                    : gepc_pkg::SIZE_W'(grid_cols_reg);

    // config registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_rows_reg <= gepc_pkg::CFG_W'(1);
            grid_cols_reg <= gepc_pkg::CFG_W'(1);
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                gepc_pkg::REG_ROWS: grid_rows_reg <= cfg_wdata;
                gepc_pkg::REG_COLS: grid_cols_reg <= cfg_wdata;
            endcase
        end
    end

    // request capture
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            budget_reg <= budget_sat;
            sr_reg     <= in_row;
            sc_reg     <= in_col;
            rows_reg   <= rows_sat;
            cols_reg   <= cols_sat;
            bad_reg    <= (gepc_pkg::SIZE_W'(in_row) >= rows_sat) ||
                          (gepc_pkg::SIZE_W'(in_col) >= cols_sat);
        end
    end

    assign row_last   = (gepc_pkg::SIZE_W'(row_reg) + 9'd1) == rows_reg;
    assign col_last   = (gepc_pkg::SIZE_W'(col_reg) + 9'd1) == cols_reg;
    assign layer_last = layer_reg == budget_reg;

    // neighbor selection per phase
    always_comb begin
        nb_out = 1'b0;
        nb_row = row_reg;
        nb_col = col_reg;
        unique case (phase_reg)
            gepc_pkg::PHASE_UP: begin
                nb_out = row_reg == '0;
                nb_row = row_reg - RW'(1);
            end
            gepc_pkg::PHASE_DOWN: begin
                nb_out = row_last;
                nb_row = row_reg + RW'(1);
            end
            gepc_pkg::PHASE_LEFT: begin
                nb_out = col_reg == '0;
                nb_col = col_reg - CW'(1);
            end
            gepc_pkg::PHASE_RIGHT: begin
                nb_out = col_last;
                nb_col = col_reg + CW'(1);
            end
            default: begin
                nb_out = 1'b0;
            end
        endcase
    end

    always_comb begin
        if (nb_out) begin
            kind_next = gepc_pkg::NB_ONE;
        end else if (layer_reg == gepc_pkg::BUDGET_W'(1) || phase_reg == gepc_pkg::PHASE_LAST) begin
            kind_next = gepc_pkg::NB_ZERO;
        end else begin
            kind_next = gepc_pkg::NB_RAM;
        end
    end

    // layer k reads the store holding layer k-1
    assign rsel      = cmd.capture ? layer_reg[0] : ~layer_reg[0];
    assign rdata_sel = rsel ? rdata1 : rdata0;

    always_comb begin
        unique case (kind_reg)
            gepc_pkg::NB_ONE: contrib = gepc_pkg::COUNT_W'(1);
            gepc_pkg::NB_RAM: contrib = rdata_sel;
            default:          contrib = '0;
        endcase
    end

    assign sum = {1'b0, acc_reg} + {1'b0, contrib};
    assign red = (sum >= {1'b0, gepc_pkg::PATH_MOD}) ? sum[29:0] - gepc_pkg::PATH_MOD
                                                      : sum[29:0];

    assign raddr   = cmd.fetch ? {RW'(sr_reg), CW'(sc_reg)} : {nb_row, nb_col};
    assign waddr   = {row_reg, col_reg};
    assign wr_cell = cmd.sweep && (phase_reg == gepc_pkg::PHASE_LAST);
    assign we0     = wr_cell && !layer_reg[0];
    assign we1     = wr_cell && layer_reg[0];

    gepc_ram #(.WIDTH(gepc_pkg::COUNT_W), .DEPTH(DEPTH)) u_ram0 (
        .aclk  (aclk),
        .we    (we0),
        .waddr (waddr),
        .wdata (red),
        .raddr (raddr),
        .rdata (rdata0)
    );

    gepc_ram #(.WIDTH(gepc_pkg::COUNT_W), .DEPTH(DEPTH)) u_ram1 (
        .aclk  (aclk),
        .we    (we1),
        .waddr (waddr),
        .wdata (red),
        .raddr (raddr),
        .rdata (rdata1)
    );

    // sweep counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= gepc_pkg::PHASE_UP;
            row_reg   <= '0;
            col_reg   <= '0;
            layer_reg <= gepc_pkg::BUDGET_W'(1);
        end else if (cmd.load) begin
            phase_reg <= gepc_pkg::PHASE_UP;
            row_reg   <= '0;
            col_reg   <= '0;
            layer_reg <= gepc_pkg::BUDGET_W'(1);
        end else if (cmd.sweep) begin
            if (phase_reg == gepc_pkg::PHASE_LAST) begin
                phase_reg <= gepc_pkg::PHASE_UP;
                if (col_last) begin
                    col_reg <= '0;
                    if (row_last) begin
                        row_reg <= '0;
                        if (!layer_last) begin
                            layer_reg <= layer_reg + gepc_pkg::BUDGET_W'(1);
                        end
                    end else begin
                        row_reg <= row_reg + RW'(1);
                    end
                end else begin
                    col_reg <= col_reg + CW'(1);
                end
            end else begin
                phase_reg <= phase_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.sweep) begin
            kind_reg <= kind_next;
            acc_reg  <= (phase_reg == gepc_pkg::PHASE_UP) ? '0 : red;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (cmd.zero_res) begin
            res_count_reg <= '0;
            res_bad_reg   <= bad_reg;
        end else if (cmd.capture) begin
            res_count_reg <= rdata_sel;
            res_bad_reg   <= 1'b0;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_count_reg <= res_count_reg;
            m_bad_reg   <= res_bad_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b00, m_count_reg};
    assign m_tuser  = m_bad_reg;

    assign status.bad_start   = bad_reg;
    assign status.budget_zero = budget_reg == '0;
    assign status.sweep_done  = wr_cell && row_last && col_last && layer_last;
    assign status.out_free    = !m_valid_reg || m_tready;

endmodule

[design/gepc_ctrl.sv]
// gepc_ctrl: controller state machine sequencing request, layer sweeps and result
// depends on gepc_pkg
module gepc_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  gepc_pkg::status_t status,
    output gepc_pkg::cmd_t    cmd
);

    gepc_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= gepc_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            gepc_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = gepc_pkg::ST_DECIDE;
                end
            end
            gepc_pkg::ST_DECIDE: begin
                if (status.bad_start || status.budget_zero) begin
                    cmd.zero_res = 1'b1;
                    state_next   = gepc_pkg::ST_DONE;
                end else begin
                    state_next = gepc_pkg::ST_SWEEP;
                end
            end
            gepc_pkg::ST_SWEEP: begin
                cmd.sweep = 1'b1;
                if (status.sweep_done) begin
                    state_next = gepc_pkg::ST_FETCH;
                end
            end
            gepc_pkg::ST_FETCH: begin
                cmd.fetch  = 1'b1;
                state_next = gepc_pkg::ST_CAPTURE;
            end
            gepc_pkg::ST_CAPTURE: begin
                cmd.capture = 1'b1;
                state_next  = gepc_pkg::ST_DONE;
            end
            gepc_pkg::ST_DONE: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = gepc_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = gepc_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

[design/grid_escape_path_counter.sv]
// grid_escape_path_counter: top level joining controller and datapath
// depends on gepc_pkg, gepc_ctrl, gepc_dp (and gepc_ram through it)
//
// usage: configure grid_rows (index 0) and grid_cols (index 1) through
// cfg_wr_en/cfg_index/cfg_wdata while idle; both reset to 1.
// each request on s_axis gives move budget and start cell; one result
// leaves on m_axis with the escaping path count mod 1000000007 in m_tdata
// and the bad start flag in m_tuser.
// a request is worked on alone: every cell of every layer steps through the
// phases up, down, left, right and last (four neighbor reads through the
// single read port of the layer store, then one write); a bad start or zero
// budget skips the sweeps and answers with a zero count; the next request is
// accepted in the cycle after the result is loaded into the output register.
// two layer stores alternate between layers, so no copy pass is needed;
// layer zero is never read from memory, so no clearing pass either.
// reset returns the controller to idle, drops m_tvalid and restores the
// grid size registers. a stalled receiver holds the result in the output
// register; the next request is taken meanwhile and its result waits
// until that register frees.
module grid_escape_path_counter #(
    parameter int ROWS_MAX  = 64,
    parameter int COLS_MAX  = 64,
    parameter int MOVES_MAX = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic [6:0]  cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // move_budget[6:0], start_row[12:7], start_col[18:13], zeros
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // path_count[29:0], zeros
    output logic        m_tuser    // bad_start
);

    gepc_pkg::cmd_t    cmd;
    gepc_pkg::status_t status;

    gepc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    gepc_dp #(
        .ROWS_MAX  (ROWS_MAX),
        .COLS_MAX  (COLS_MAX),
        .MOVES_MAX (MOVES_MAX)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .cmd       (cmd),
        .status    (status),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

`ifndef SYNTH
    a_bad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata[29:0] == 30'd0))
        else $error("bad start result with nonzero count");

    a_count_mod: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[29:0] < gepc_pkg::PATH_MOD))
        else $error("path count not reduced");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request taken while another is in progress");

    a_write_in_sweep: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.sweep |-> !(cmd.load || cmd.fetch || cmd.capture || cmd.out_load))
        else $error("conflicting commands during sweep");
`endif

endmodule
